FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

FILE: sv/phx_pkg.sv
// ----------------------------------------------------------------------------
// phx_pkg
// types, character codes and classifiers for the hex/decimal text parser
// ----------------------------------------------------------------------------
package phx_pkg;

  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [7:0]            char_t;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_PCT   = 8'h25;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_LPAR  = 8'h28;
  localparam char_t CH_AT    = 8'h40;
  localparam char_t CH_HASH  = 8'h23;
  localparam char_t CH_UX    = 8'h58;
  localparam char_t CH_LX    = 8'h78;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LF_HEX = 8'h66;
  localparam logic [3:0] TEN = 4'd10;

  typedef enum logic [5:0] {
    PH_SKIP     = 6'b000001,
    PH_HEXSKIP  = 6'b000010,
    PH_HEX      = 6'b000100,
    PH_DEC      = 6'b001000,
    PH_DONE_DEC = 6'b010000,
    PH_DONE_HEX = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic in_skip;
    logic prev_zero;
    logic acc_zero;
  } stat_t;

  function automatic logic is_filler(input char_t c);
    return (c == CH_SPACE) || (c == CH_FF) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_TAB) || (c == CH_VT) || (c == CH_ZERO) || (c == CH_DOLLAR) ||
           (c == CH_PCT) || (c == CH_STAR) || (c == CH_LPAR) || (c == CH_AT) ||
           (c == CH_HASH);
  endfunction

  function automatic logic is_dec(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input char_t c);
    logic [4:0] v;
    v = 5'h10;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = {1'b0, 4'(c - CH_ZERO)};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      v = {1'b0, 4'(c - CH_UA) + TEN};
    end else if ((c >= CH_LA) && (c <= CH_LF_HEX)) begin
      v = {1'b0, 4'(c - CH_LA) + TEN};
    end
    return v;
  endfunction

endpackage

FILE: sv/phx_if.sv
// ----------------------------------------------------------------------------
// phx_if
// valid/ready channels for text bytes in and parsed numbers out
// ----------------------------------------------------------------------------
interface phx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       last_char;

  modport source (output valid, output char_code, output char_present,
                  output last_char, input ready);
  modport sink   (input valid, input char_code, input char_present,
                  input last_char, output ready);
endinterface

interface phx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] parsed_value;
  logic        was_hex;

  modport source (output valid, output parsed_value, output was_hex, input ready);
  modport sink   (input valid, input parsed_value, input was_hex, output ready);
endinterface

FILE: sv/phx_in_reg.sv
// ----------------------------------------------------------------------------
// phx_in_reg
// input register stage, refills in the same cycle it is drained
// ----------------------------------------------------------------------------
module phx_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  phx_in_if.sink         in_ch,
  input  logic           s1_take,
  output logic           s1_valid,
  output phx_pkg::item_t s1_item
);

  logic           valid_r;
  phx_pkg::item_t item_r;

  assign in_ch.ready = !valid_r || s1_take;
  assign s1_valid    = valid_r;
  assign s1_item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.char_code    <= in_ch.char_code;
      item_r.char_present <= in_ch.char_present;
      item_r.last_char    <= in_ch.last_char;
    end
  end

endmodule

FILE: sv/phx_parse.sv
// ----------------------------------------------------------------------------
// phx_parse
// parse state update per byte and result register
// ----------------------------------------------------------------------------
module phx_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  input  phx_pkg::item_t s1_item,
  output logic           s1_take,
  output phx_pkg::stat_t stat,
  phx_out_if.source      out_ch
);

  phx_pkg::phase_t phase_r, phase_nxt;
  logic            prev_zero_r, prev_zero_nxt;
  phx_pkg::value_t acc_r, acc_nxt;
  logic            out_valid_r;
  logic [31:0]     value_r;
  logic            hex_r;

  phx_pkg::char_t  c;
  logic            filler;
  logic            dec;
  logic [4:0]      hv;
  logic            hex_mode;
  phx_pkg::value_t acc_x10;
  phx_pkg::value_t acc_x16;
  logic            out_free;

  assign c        = s1_item.char_code;
  assign filler   = phx_pkg::is_filler(c);
  assign dec      = phx_pkg::is_dec(c);
  assign hv       = phx_pkg::hex_val(c);
  assign acc_x10  = (acc_r << 3) + (acc_r << 1) + phx_pkg::VALUE_BITS'(hv[3:0]);
  assign acc_x16  = (acc_r << 4) | phx_pkg::VALUE_BITS'(hv[3:0]);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_take  = s1_valid && (!s1_item.last_char || out_free);

  // next parse state for a present byte
  always_comb begin
    phase_nxt     = phase_r;
    prev_zero_nxt = prev_zero_r;
    acc_nxt       = acc_r;
    if (s1_item.char_present) begin
      case (phase_r)
        phx_pkg::PH_SKIP: begin
          if (filler) begin
            prev_zero_nxt = (c == phx_pkg::CH_ZERO);
          end else if (prev_zero_r && ((c == phx_pkg::CH_UX) || (c == phx_pkg::CH_LX))) begin
            phase_nxt = phx_pkg::PH_HEXSKIP;
          end else if (dec) begin
            acc_nxt   = phx_pkg::VALUE_BITS'(hv[3:0]);
            phase_nxt = phx_pkg::PH_DEC;
          end else begin
            phase_nxt = phx_pkg::PH_DONE_DEC;
          end
        end
        phx_pkg::PH_HEXSKIP: begin
          if (!filler) begin
            if (!hv[4]) begin
              acc_nxt   = phx_pkg::VALUE_BITS'(hv[3:0]);
              phase_nxt = phx_pkg::PH_HEX;
            end else begin
              phase_nxt = phx_pkg::PH_DONE_HEX;
            end
          end
        end
        phx_pkg::PH_HEX: begin
          if (!hv[4]) begin
            acc_nxt = acc_x16;
          end else begin
            phase_nxt = phx_pkg::PH_DONE_HEX;
          end
        end
        phx_pkg::PH_DEC: begin
          if (dec) begin
            acc_nxt = acc_x10;
          end else begin
            phase_nxt = phx_pkg::PH_DONE_DEC;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign hex_mode = (phase_nxt == phx_pkg::PH_HEXSKIP) || (phase_nxt == phx_pkg::PH_HEX) ||
                    (phase_nxt == phx_pkg::PH_DONE_HEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= phx_pkg::PH_SKIP;
      prev_zero_r <= 1'b0;
      acc_r       <= '0;
    end else if (s1_take) begin
      if (s1_item.last_char) begin
        phase_r     <= phx_pkg::PH_SKIP;
        prev_zero_r <= 1'b0;
        acc_r       <= '0;
      end else begin
        phase_r     <= phase_nxt;
        prev_zero_r <= prev_zero_nxt;
        acc_r       <= acc_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take && s1_item.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_item.last_char) begin
      value_r <= phx_pkg::OUT_BITS'(64'(acc_nxt));
      hex_r   <= hex_mode;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parsed_value = value_r;
  assign out_ch.was_hex      = hex_r;

  assign stat.in_skip   = (phase_r == phx_pkg::PH_SKIP);
  assign stat.prev_zero = prev_zero_r;
  assign stat.acc_zero  = (acc_r == '0);

endmodule

FILE: sv/prefixed_hex_decimal_text_to_number_top.sv
// ----------------------------------------------------------------------------
// prefixed_hex_decimal_text_to_number_top: text bytes to unsigned number
// one byte per cycle unless a last byte waits for the held result to go;
// rate set by the x10/x16 shift-add in phx_parse; input and result registered
// synchronous active-low reset clears parse state and both valid flags
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prefixed_hex_decimal_text_to_number_top (
  input  logic      clk,
  input  logic      rst_n,
  phx_in_if.sink    in_ch,
  phx_out_if.source out_ch
);

  logic           s1_take;
  logic           s1_valid;
  phx_pkg::item_t s1_item;
  phx_pkg::stat_t stat;

  phx_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  phx_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take),
    .stat     (stat),
    .out_ch   (out_ch)
  );

  // bytes that are not last never stall
  `ASSERT_IMPL(a_mid_no_stall, s1_valid && !s1_item.last_char, s1_take)
  // a taken last byte always shows up as a result
  `ASSERT_NEXT(a_last_gives_result, s1_take && s1_item.last_char, out_ch.valid)
  // parse state is back at its reset value after the last byte
  `ASSERT_NEXT(a_last_resets, s1_take && s1_item.last_char,
               stat.in_skip && stat.acc_zero && !stat.prev_zero)

endmodule

FILE: tb/sv/phx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phx_checker
// watches both channels of the text-to-number parser, keeps its own model of
// the parse state, and compares every result transfer with the oldest
// predicted number; mismatch and pending counts go back to the bench top
// ----------------------------------------------------------------------------
module phx_checker (
  input  logic clk,
  input  logic rst_n,
  phx_in_if    in_mon,
  phx_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [phx_pkg::OUT_BITS-1:0] number;
    logic                         hex;
  } parsed_t;

  localparam phx_pkg::value_t DEC_BASE  = phx_pkg::value_t'(10);
  localparam phx_pkg::value_t HEX_BASE  = phx_pkg::value_t'(16);
  localparam logic [4:0]      NOT_HEX   = 5'd16;
  localparam phx_pkg::char_t  DIGIT_TEN = 8'd10;

  phx_pkg::phase_t phase;
  logic            prev_zero;
  phx_pkg::value_t acc;
  parsed_t         expected_numbers[$];
  parsed_t         want;
  int              errors;

  function automatic logic pad_char(input phx_pkg::char_t c);
    case (c)
      phx_pkg::CH_SPACE, phx_pkg::CH_FF, phx_pkg::CH_LF, phx_pkg::CH_CR,
      phx_pkg::CH_TAB, phx_pkg::CH_VT, phx_pkg::CH_ZERO, phx_pkg::CH_DOLLAR,
      phx_pkg::CH_PCT, phx_pkg::CH_STAR, phx_pkg::CH_LPAR, phx_pkg::CH_AT,
      phx_pkg::CH_HASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic dec_char(input phx_pkg::char_t c);
    return (c >= phx_pkg::CH_ZERO) && (c <= phx_pkg::CH_NINE);
  endfunction

  function automatic logic [4:0] nibble_of(input phx_pkg::char_t c);
    if (dec_char(c)) return 5'(c - phx_pkg::CH_ZERO);
    if ((c >= phx_pkg::CH_UA) && (c <= phx_pkg::CH_UF))
      return 5'(c - phx_pkg::CH_UA + DIGIT_TEN);
    if ((c >= phx_pkg::CH_LA) && (c <= phx_pkg::CH_LF_HEX))
      return 5'(c - phx_pkg::CH_LA + DIGIT_TEN);
    return NOT_HEX;
  endfunction

  task automatic clear_parse();
    phase     = phx_pkg::PH_SKIP;
    prev_zero = 1'b0;
    acc       = '0;
  endtask

  task automatic absorb_char(input phx_pkg::char_t c);
    logic [4:0] nib;
    nib = nibble_of(c);
    case (phase)
      phx_pkg::PH_SKIP: begin
        if (pad_char(c)) begin
          prev_zero = (c == phx_pkg::CH_ZERO);
        end else if (prev_zero && ((c == phx_pkg::CH_UX) || (c == phx_pkg::CH_LX))) begin
          phase = phx_pkg::PH_HEXSKIP;
        end else if (dec_char(c)) begin
          acc   = phx_pkg::value_t'(c - phx_pkg::CH_ZERO);
          phase = phx_pkg::PH_DEC;
        end else begin
          phase = phx_pkg::PH_DONE_DEC;
        end
      end
      phx_pkg::PH_HEXSKIP: begin
        if (!pad_char(c)) begin
          if (nib != NOT_HEX) begin
            acc   = phx_pkg::value_t'(nib);
            phase = phx_pkg::PH_HEX;
          end else begin
            phase = phx_pkg::PH_DONE_HEX;
          end
        end
      end
      phx_pkg::PH_HEX: begin
        if (nib != NOT_HEX) begin
          acc = acc * HEX_BASE + phx_pkg::value_t'(nib);
        end else begin
          phase = phx_pkg::PH_DONE_HEX;
        end
      end
      phx_pkg::PH_DEC: begin
        if (dec_char(c)) begin
          acc = acc * DEC_BASE + phx_pkg::value_t'(c - phx_pkg::CH_ZERO);
        end else begin
          phase = phx_pkg::PH_DONE_DEC;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_numbers.delete();
      errors = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result: parsed_value %0h was_hex %0b",
                 out_mon.parsed_value, out_mon.was_hex);
          errors++;
        end else begin
          want = expected_numbers.pop_front();
          if (out_mon.parsed_value !== want.number) begin
            $error("parsed_value: expected %0h, actual %0h",
                   want.number, out_mon.parsed_value);
            errors++;
          end
          if (out_mon.was_hex !== want.hex) begin
            $error("was_hex: expected %0b, actual %0b", want.hex, out_mon.was_hex);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.char_present) absorb_char(in_mon.char_code);
        if (in_mon.last_char) begin
          want.number = acc[phx_pkg::OUT_BITS-1:0];
          want.hex    = (phase == phx_pkg::PH_HEXSKIP) || (phase == phx_pkg::PH_HEX) ||
                        (phase == phx_pkg::PH_DONE_HEX);
          expected_numbers.push_back(want);
          clear_parse();
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_numbers.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// bench for the prefixed hex/decimal text parser: a short directed set of
// strings, then random strings, mostly well-formed hex and decimal numbers
// with random padding and trailing bytes, with random idle bursts on both
// channels until CALM_ITEMS items are sent; checking is done by phx_checker
// ----------------------------------------------------------------------------
module tb_top;

  localparam int             TOTAL_ITEMS = 1300;
  localparam int             CALM_ITEMS  = 1100;
  localparam phx_pkg::char_t PAD_SET [13] = '{
    phx_pkg::CH_SPACE, phx_pkg::CH_FF, phx_pkg::CH_LF, phx_pkg::CH_CR, phx_pkg::CH_TAB,
    phx_pkg::CH_VT, phx_pkg::CH_ZERO, phx_pkg::CH_DOLLAR, phx_pkg::CH_PCT,
    phx_pkg::CH_STAR, phx_pkg::CH_LPAR, phx_pkg::CH_AT, phx_pkg::CH_HASH};

  logic clk;
  logic rst_n;
  bit   idling;
  int   fail_count;
  int   pending;
  int   items_sent;

  phx_in_if  in_bus();
  phx_out_if out_bus();

  prefixed_hex_decimal_text_to_number_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  phx_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side stalls
  initial begin
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else if (idling && ($urandom_range(0, 5) == 0)) begin
        out_bus.ready <= 1'b0;
        stall = $urandom_range(1, 16) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input phx_pkg::char_t c, input logic present, input logic last);
    int gap;
    if (idling && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 16);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.char_code    <= c;
    in_bus.char_present <= present;
    in_bus.last_char    <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    if (items_sent >= CALM_ITEMS) idling <= 1'b0;
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic phx_pkg::char_t random_pad();
    return PAD_SET[$urandom_range(0, 12)];
  endfunction

  function automatic phx_pkg::char_t random_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return phx_pkg::CH_ZERO + phx_pkg::char_t'(r);
    if (r < 16) return phx_pkg::CH_UA + phx_pkg::char_t'(r - 10);
    return phx_pkg::CH_LA + phx_pkg::char_t'(r - 16);
  endfunction

  task automatic build_text(output phx_pkg::char_t t[$]);
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    t = {};
    n = $urandom_range(0, 3);
    repeat (n) t.push_back(random_pad());
    case (kind)
      0, 1, 2, 3: begin
        t.push_back(phx_pkg::CH_ZERO);
        t.push_back($urandom_range(0, 1) ? phx_pkg::CH_UX : phx_pkg::CH_LX);
        n = $urandom_range(0, 2);
        repeat (n) t.push_back(random_pad());
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        repeat (n) t.push_back(random_hex_digit());
      end
      4, 5, 6: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
        repeat (n) t.push_back(phx_pkg::CH_ZERO + phx_pkg::char_t'($urandom_range(0, 9)));
      end
      7: begin
        // broken prefixes
        if ($urandom_range(0, 1)) begin
          t.push_back(phx_pkg::CH_DOLLAR);
          t.push_back($urandom_range(0, 1) ? phx_pkg::CH_UX : phx_pkg::CH_LX);
        end else begin
          t.push_back(phx_pkg::CH_ZERO);
          t.push_back(phx_pkg::CH_LX);
          t.push_back(phx_pkg::char_t'($urandom_range(0, 255)));
        end
      end
      default: begin
        t = {};
        n = $urandom_range(0, 8);
        repeat (n) t.push_back(phx_pkg::char_t'($urandom_range(0, 255)));
      end
    endcase
    if (kind <= 7) begin
      n = $urandom_range(0, 3);
      repeat (n) t.push_back(phx_pkg::char_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_text(input phx_pkg::char_t t[$]);
    bit absent_end;
    absent_end = (t.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (t[i]) begin
      if ($urandom_range(0, 11) == 0) send_item(phx_pkg::char_t'($urandom), 1'b0, 1'b0);
      send_item(t[i], 1'b1, (i == t.size() - 1) && !absent_end);
    end
    if (absent_end) send_item(phx_pkg::char_t'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    phx_pkg::char_t text[$];
    bit             drained_mid;
    idling              = 1'b1;
    items_sent          = 0;
    drained_mid         = 1'b0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.char_code    = '0;
    in_bus.char_present = 1'b0;
    in_bus.last_char    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty string
    send_item(8'hFF, 1'b0, 1'b1);
    // hex with mixed-case letters and an absent byte inside
    send_item(phx_pkg::CH_ZERO, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LX, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(phx_pkg::CH_UF, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LF_HEX, 1'b1, 1'b0);
    send_item(phx_pkg::CH_UA, 1'b1, 1'b0);
    send_item(phx_pkg::CH_NINE, 1'b1, 1'b1);
    // prefix followed only by filler
    send_item(phx_pkg::CH_ZERO, 1'b1, 1'b0);
    send_item(phx_pkg::CH_UX, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LPAR, 1'b1, 1'b1);
    // high byte ends the parse, digit after it ignored
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(phx_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1);
    // lone zero byte
    send_item(8'h00, 1'b1, 1'b1);
    // decimal ended by a letter
    send_item(phx_pkg::CH_ZERO + 8'd7, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LF_HEX + 8'd1, 1'b1, 1'b1);
    // x after non-zero filler is not a prefix
    send_item(phx_pkg::CH_HASH, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LX, 1'b1, 1'b1);
    // prefix followed by a non-digit
    send_item(phx_pkg::CH_ZERO, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LX, 1'b1, 1'b0);
    send_item(phx_pkg::CH_LF_HEX + 8'd1, 1'b1, 1'b1);
    // filler around the prefix
    send_item(phx_pkg::CH_VT, 1'b1, 1'b0);
    send_item(phx_pkg::CH_ZERO, 1'b1, 1'b0);
    send_item(phx_pkg::CH_UX, 1'b1, 1'b0);
    send_item(phx_pkg::CH_TAB, 1'b1, 1'b0);
    send_item(phx_pkg::CH_ZERO + 8'd1, 1'b1, 1'b1);
    drain_results();

    while (items_sent < TOTAL_ITEMS) begin
      if (!drained_mid && (items_sent >= TOTAL_ITEMS / 2)) begin
        drain_results();
        drained_mid = 1'b1;
      end
      build_text(text);
      send_text(text);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
